// ===== sv/rk4mp_pkg.sv =====
// Shared types, constants and arithmetic helpers of the fourth-order Runge-Kutta particle step.
package rk4mp_pkg;

   localparam int FRAC_BITS = 24;
   localparam int SINE_DEPTH = 1024;
   localparam int SINE_IDX_BITS = $clog2(SINE_DEPTH);
   localparam int SINE_AW = SINE_IDX_BITS + 1;
   localparam int SINE_W = FRAC_BITS + 1;
   localparam int STAGE_LAYERS = 7;
   localparam int RK_STAGES = 4;
   localparam int CHANNELS = 6;

   localparam longint unsigned PI_Q30 = 64'd3373259426;

   typedef logic signed [31:0] q_type;
   typedef logic signed [34:0] acc_type;
   typedef logic [1:0] stage_idx_type;
   typedef logic [SINE_W-1:0] sine_rom_type [0:SINE_DEPTH];

   localparam q_type ONE_Q = 32'sd16777216;
   localparam q_type PI_Q = q_type'((PI_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
   localparam q_type EPS_Q = q_type'((64'd16777216 + 64'd50) / 64'd100);
   localparam logic [31:0] HALF_TURN = 32'h0080_0000;
   localparam logic [30:0] TIME_STEP_RESET = 31'd16777;
   localparam logic [19:0] RECIP3 = 20'd699051;
   localparam int RECIP3_SHIFT = 21;

   localparam stage_idx_type STAGE_1 = 2'd0;
   localparam stage_idx_type STAGE_2 = 2'd1;
   localparam stage_idx_type STAGE_3 = 2'd2;
   localparam stage_idx_type STAGE_4 = 2'd3;

   localparam logic REG_FIELD_RATIO = 1'b0;
   localparam logic REG_TIME_STEP = 1'b1;

   typedef struct {
      q_type p [3];
      q_type v [3];
      q_type t;
      q_type lim;
      q_type sp [3];
      q_type sv [3];
      acc_type acc_p [3];
      acc_type acc_v [3];
   } rk4mp_item_type;

   typedef struct packed {
      q_type avg;
      q_type dif;
      q_type pidif;
      logic [30:0] dt;
   } rk4mp_field_type;

   typedef struct {
      rk4mp_item_type item;
      q_type kp [3];
      logic [SINE_W-1:0] s_raw;
      logic [SINE_W-1:0] c_raw;
      logic s_neg;
      logic c_neg;
      q_type m_s;
      q_type m_c;
      q_type bz;
      q_type bx;
      q_type pr [4];
      q_type d [3];
      q_type kv [3];
   } rk4mp_work_type;

   function automatic q_type sat_q(input logic signed [39:0] a);
      if (a > 40'sh007FFFFFFF) begin
         return 32'sh7FFFFFFF;
      end else if (a < -40'sh0080000000) begin
         return 32'sh80000000;
      end
      return a[31:0];
   endfunction

   function automatic q_type mul_q(input q_type a, input q_type b);
      logic signed [63:0] prod;
      logic signed [63:0] rnd;
      prod = 64'(a) * 64'(b);
      rnd = (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return sat_q(rnd[39:0]);
   endfunction

   function automatic q_type add_q(input q_type a, input q_type b);
      return sat_q(40'(a) + 40'(b));
   endfunction

   function automatic q_type sub_q(input q_type a, input q_type b);
      return sat_q(40'(a) - 40'(b));
   endfunction

   function automatic q_type neg_q(input q_type a);
      return sat_q(-40'(a));
   endfunction

   function automatic q_type half_q(input q_type a);
      logic signed [32:0] s;
      s = 33'(a) + 33'sd1;
      return s[32:1];
   endfunction

   function automatic logic [SINE_AW-1:0] sine_addr(input logic [31:0] u);
      logic [SINE_IDX_BITS-1:0] idx;
      idx = u[FRAC_BITS-2 -: SINE_IDX_BITS];
      if (u[FRAC_BITS-1]) begin
         return SINE_AW'(SINE_DEPTH) - {1'b0, idx};
      end
      return {1'b0, idx};
   endfunction

   // Shift-and-subtract quotient, used only while the sine table is built.
   function automatic longint unsigned udiv_u64(input longint unsigned n,
                                                input longint unsigned d);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], n[b]};
         if (rem >= d) begin
            rem = rem - d;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      longint unsigned a;
      longint unsigned a2;
      longint unsigned term;
      longint unsigned q;
      longint sum;
      bit minus;
      for (int i = 0; i <= SINE_DEPTH; i++) begin
         a = (PI_Q30 * 64'(i) + 64'(SINE_DEPTH)) >> (SINE_IDX_BITS + 1);
         a2 = (a * a + (64'd1 << 29)) >> 30;
         term = a;
         sum = longint'(a);
         minus = 1'b1;
         for (int k = 2; k < 64; k += 2) begin
            if (term != 0) begin
               term = udiv_u64((term * a2) >> 30, 64'(k * (k + 1)));
               sum = minus ? sum - longint'(term) : sum + longint'(term);
               minus = !minus;
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         q = (64'(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
         if (q > (64'd1 << FRAC_BITS)) begin
            q = 64'd1 << FRAC_BITS;
         end
         rom[i] = q[SINE_W-1:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

// ===== sv/rk4mp_if.sv =====
// Valid-ready channel interfaces for particle states going in and results coming out.
interface rk4mp_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic signed [31:0] time_now;
   logic signed [31:0] time_limit;
   modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, time_now,
                   time_limit, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, time_now,
                 time_limit, output ready);
endinterface

interface rk4mp_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] new_x;
   logic signed [31:0] new_y;
   logic signed [31:0] new_z;
   logic signed [31:0] new_vx;
   logic signed [31:0] new_vy;
   logic signed [31:0] new_vz;
   logic signed [31:0] new_time;
   logic keep_going;
   modport source (output valid, new_x, new_y, new_z, new_vx, new_vy, new_vz, new_time,
                   keep_going, input ready);
   modport sink (input valid, new_x, new_y, new_z, new_vx, new_vy, new_vz, new_time,
                 keep_going, output ready);
endinterface

// ===== sv/rk4_magnetic_particle_step_top.sv =====
// Top level of the Runge-Kutta particle step: register port, four stages, divide by six, output.
// Each item is one complete electron state and leaves as the state after one time step; a new
// item is accepted in every cycle that the output register can move. The pipeline is built from
// the four Runge-Kutta stages of seven layers each (sine lookup, two field products, the cross
// product, the difference, the time-step product and the state update), three layers of the
// rounded divide by six and the output register. A stall on the result side holds the whole
// pipeline in place. The user must write the field ratio and time step through the register
// port only while no item is in flight; the block itself does not enforce this.
module rk4_magnetic_particle_step_top import rk4mp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   rk4mp_req_if.sink   req,
   rk4mp_rsp_if.source rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   typedef struct {
      q_type old [CHANNELS];
      logic neg [CHANNELS];
      logic [32:0] n [CHANNELS];
      logic [14:0] qh [CHANNELS];
      logic [1:0] rh [CHANNELS];
      logic [32:0] q [CHANNELS];
      q_type t;
      q_type lim;
   } div_type;

   typedef struct {
      q_type nv [CHANNELS];
      q_type nt;
      logic keep;
   } out_type;

   q_type field_ratio_ff;
   logic [30:0] time_step_ff;
   rk4mp_field_type field_in;
   rk4mp_field_type field_ff;
   rk4mp_field_type field_stage;
   logic pipe_en;

   logic st_vld [RK_STAGES+1];
   rk4mp_item_type st_item [RK_STAGES+1];

   div_type div_in [3];
   div_type div_ff [3];
   logic [2:0] div_vld_ff;
   out_type out_in;
   out_type out_ff;
   logic rsp_vld_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ratio_ff <= '0;
         time_step_ff <= TIME_STEP_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            REG_FIELD_RATIO: field_ratio_ff <= signed'(pwdata);
            REG_TIME_STEP: time_step_ff <= pwdata[30:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_FIELD_RATIO: prdata = field_ratio_ff;
         REG_TIME_STEP: prdata = {1'b0, time_step_ff};
      endcase
   end

   always_comb begin
      logic signed [32:0] avg_sum;
      logic signed [32:0] dif_sum;
      avg_sum = 33'(ONE_Q) + 33'(field_ratio_ff);
      dif_sum = 33'(ONE_Q) - 33'(field_ratio_ff);
      field_in.avg = avg_sum[32:1];
      field_in.dif = dif_sum[32:1];
      field_in.pidif = mul_q(PI_Q, dif_sum[32:1]);
      field_in.dt = time_step_ff;
   end

   always_ff @(posedge clock) begin
      field_ff <= field_in;
   end

   // The first layer needs the time step in the cycle right after a register write.
   always_comb begin
      field_stage = field_ff;
      field_stage.dt = time_step_ff;
   end

   assign pipe_en = !rsp_vld_ff || rsp.ready;
   assign req.ready = pipe_en;

   always_comb begin
      st_vld[0] = req.valid;
      st_item[0].p[0] = req.pos_x;
      st_item[0].p[1] = req.pos_y;
      st_item[0].p[2] = req.pos_z;
      st_item[0].v[0] = req.vel_x;
      st_item[0].v[1] = req.vel_y;
      st_item[0].v[2] = req.vel_z;
      st_item[0].t = req.time_now;
      st_item[0].lim = req.time_limit;
      for (int i = 0; i < 3; i++) begin
         st_item[0].sp[i] = st_item[0].p[i];
         st_item[0].sv[i] = st_item[0].v[i];
         st_item[0].acc_p[i] = '0;
         st_item[0].acc_v[i] = '0;
      end
   end

   for (genvar g = 0; g < RK_STAGES; g++) begin : g_stage
      rk4mp_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (pipe_en),
         .stage_idx(stage_idx_type'(g)),
         .field    (field_stage),
         .in_vld   (st_vld[g]),
         .in_item  (st_item[g]),
         .out_vld  (st_vld[g+1]),
         .out_item (st_item[g+1])
      );
   end

   always_comb begin
      acc_type sum;
      logic [34:0] mag;
      logic [34:0] m3;
      logic [35:0] ph;
      logic [15:0] hi;
      logic [15:0] r16;
      logic [18:0] x2;
      logic [38:0] pl;
      logic signed [39:0] inc;

      div_in[0] = '{default: '0};
      div_in[0].t = st_item[RK_STAGES].t;
      div_in[0].lim = st_item[RK_STAGES].lim;
      for (int c = 0; c < CHANNELS; c++) begin
         if (c < 3) begin
            sum = st_item[RK_STAGES].acc_p[c];
            div_in[0].old[c] = st_item[RK_STAGES].p[c];
         end else begin
            sum = st_item[RK_STAGES].acc_v[c-3];
            div_in[0].old[c] = st_item[RK_STAGES].v[c-3];
         end
         div_in[0].neg[c] = sum[34];
         mag = sum[34] ? unsigned'(-sum) : unsigned'(sum);
         m3 = mag + 35'd3;
         div_in[0].n[c] = m3[33:1];
      end

      div_in[1] = div_ff[0];
      for (int c = 0; c < CHANNELS; c++) begin
         hi = div_ff[0].n[c][32:17];
         ph = 36'(hi) * 36'(RECIP3);
         div_in[1].qh[c] = ph[RECIP3_SHIFT +: 15];
         r16 = hi - 16'(ph[RECIP3_SHIFT +: 15]) * 16'd3;
         div_in[1].rh[c] = r16[1:0];
      end

      div_in[2] = div_ff[1];
      for (int c = 0; c < CHANNELS; c++) begin
         x2 = {div_ff[1].rh[c], div_ff[1].n[c][16:0]};
         pl = 39'(x2) * 39'(RECIP3);
         div_in[2].q[c] = {1'b0, div_ff[1].qh[c], 17'b0} + 33'(pl[RECIP3_SHIFT +: 17]);
      end

      for (int c = 0; c < CHANNELS; c++) begin
         inc = 40'(signed'({1'b0, div_ff[2].q[c]}));
         if (div_ff[2].neg[c]) begin
            inc = -inc;
         end
         out_in.nv[c] = sat_q(40'(div_ff[2].old[c]) + inc);
      end
      out_in.nt = add_q(div_ff[2].t, signed'({1'b0, field_ff.dt}));
      out_in.keep = (out_in.nv[2] < ONE_Q) && (out_in.nv[2] > -EPS_Q)
                    && (out_in.nt < div_ff[2].lim);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff <= '0;
         rsp_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         div_vld_ff <= {div_vld_ff[1:0], st_vld[RK_STAGES]};
         rsp_vld_ff <= div_vld_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         div_ff <= div_in;
         out_ff <= out_in;
      end
   end

   assign rsp.valid = rsp_vld_ff;
   assign rsp.new_x = out_ff.nv[0];
   assign rsp.new_y = out_ff.nv[1];
   assign rsp.new_z = out_ff.nv[2];
   assign rsp.new_vx = out_ff.nv[3];
   assign rsp.new_vy = out_ff.nv[4];
   assign rsp.new_vz = out_ff.nv[5];
   assign rsp.new_time = out_ff.nt;
   assign rsp.keep_going = out_ff.keep;

   a_reset_clears_output: assert property (@(posedge clock) $past(reset) |-> !rsp_vld_ff)
      else $error("result valid right after reset");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(div_vld_ff) && $stable(rsp_vld_ff))
      else $error("pipeline moved during a stall");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp.ready) |-> !req.ready)
      else $error("input taken while the output is stalled");

   a_keep_inside_bounds: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && out_ff.keep) |-> (out_ff.nv[2] < ONE_Q) && (out_ff.nv[2] > -EPS_Q))
      else $error("keep_going set with z outside the run region");

endmodule

// ===== sv/rk4mp_stage.sv =====
// One Runge-Kutta stage: field lookup, Lorentz derivative and state update over seven layers.
module rk4mp_stage import rk4mp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  stage_idx_type   stage_idx,
   input  rk4mp_field_type field,
   input  logic            in_vld,
   input  rk4mp_item_type  in_item,
   output logic            out_vld,
   output rk4mp_item_type  out_item
);

   rk4mp_work_type w_in [STAGE_LAYERS];
   rk4mp_work_type w_ff [STAGE_LAYERS];
   logic [STAGE_LAYERS-1:0] vld_ff;

   always_comb begin
      logic [31:0] zs;
      logic [31:0] zc;
      q_type sval;
      q_type cval;
      q_type dt_q;
      q_type dp;
      q_type dv;
      logic half;
      logic dbl;
      dt_q = signed'({1'b0, field.dt});
      half = (stage_idx == STAGE_1) || (stage_idx == STAGE_2);
      dbl = (stage_idx == STAGE_2) || (stage_idx == STAGE_3);

      w_in[0] = '{default: '0};
      w_in[0].item = in_item;
      zs = in_item.sp[2];
      zc = zs + HALF_TURN;
      for (int i = 0; i < 3; i++) begin
         w_in[0].kp[i] = mul_q(in_item.sv[i], dt_q);
      end
      w_in[0].s_raw = SINE_ROM[sine_addr(zs)];
      w_in[0].c_raw = SINE_ROM[sine_addr(zc)];
      w_in[0].s_neg = zs[FRAC_BITS];
      w_in[0].c_neg = zc[FRAC_BITS];

      w_in[1] = w_ff[0];
      sval = signed'(32'(w_ff[0].s_raw));
      cval = signed'(32'(w_ff[0].c_raw));
      if (w_ff[0].s_neg) begin
         sval = -sval;
      end
      if (w_ff[0].c_neg) begin
         cval = -cval;
      end
      w_in[1].m_s = mul_q(field.pidif, sval);
      w_in[1].m_c = mul_q(field.dif, cval);

      w_in[2] = w_ff[1];
      w_in[2].bz = add_q(field.avg, w_ff[1].m_c);
      w_in[2].bx = mul_q(w_ff[1].m_s, w_ff[1].item.sp[0]);

      w_in[3] = w_ff[2];
      w_in[3].pr[0] = mul_q(w_ff[2].bz, w_ff[2].item.sv[1]);
      w_in[3].pr[1] = mul_q(w_ff[2].bz, w_ff[2].item.sv[0]);
      w_in[3].pr[2] = mul_q(w_ff[2].bx, w_ff[2].item.sv[2]);
      w_in[3].pr[3] = mul_q(w_ff[2].bx, w_ff[2].item.sv[1]);

      w_in[4] = w_ff[3];
      w_in[4].d[0] = neg_q(w_ff[3].pr[0]);
      w_in[4].d[1] = sub_q(w_ff[3].pr[1], w_ff[3].pr[2]);
      w_in[4].d[2] = w_ff[3].pr[3];

      w_in[5] = w_ff[4];
      for (int i = 0; i < 3; i++) begin
         w_in[5].kv[i] = mul_q(w_ff[4].d[i], dt_q);
      end

      w_in[6] = w_ff[5];
      for (int i = 0; i < 3; i++) begin
         dp = half ? half_q(w_ff[5].kp[i]) : w_ff[5].kp[i];
         dv = half ? half_q(w_ff[5].kv[i]) : w_ff[5].kv[i];
         w_in[6].item.sp[i] = add_q(w_ff[5].item.p[i], dp);
         w_in[6].item.sv[i] = add_q(w_ff[5].item.v[i], dv);
         w_in[6].item.acc_p[i] = w_ff[5].item.acc_p[i]
                                 + (dbl ? (35'(w_ff[5].kp[i]) <<< 1) : 35'(w_ff[5].kp[i]));
         w_in[6].item.acc_v[i] = w_ff[5].item.acc_v[i]
                                 + (dbl ? (35'(w_ff[5].kv[i]) <<< 1) : 35'(w_ff[5].kv[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGE_LAYERS-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff <= w_in;
      end
   end

   assign out_vld = vld_ff[STAGE_LAYERS-1];
   assign out_item = w_ff[STAGE_LAYERS-1].item;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the Runge-Kutta particle step on random electron states.
module tb import rk4mp_pkg::*; ();

   typedef struct {
      q_type p [3];
      q_type v [3];
      q_type t;
      q_type lim;
   } particle_type;

   typedef struct {
      q_type np [3];
      q_type nv [3];
      q_type nt;
      logic  go;
   } step_result_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [2:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   rk4mp_req_if req ();
   rk4mp_rsp_if rsp ();

   rk4_magnetic_particle_step_top u_top (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   longint field_c0;
   longint step_dt;
   longint sine_tab [0:1024];

   particle_type pending_states [$];
   step_result_type expected_steps [$];
   int errors;
   longint cycle_count;
   int gap_left;
   int burst_left;
   int hold_left;
   bit hold_request;
   bit stim_done;
   particle_type st;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint fmul(longint a, longint b);
      return sat32((a * b + (64'sd1 <<< 23)) >>> 24);
   endfunction

   function automatic longint fhalf(longint a);
      return (a + 1) >>> 1;
   endfunction

   function automatic longint div_round6(longint s);
      if (s >= 0) return (s + 3) / 6;
      return -((-s + 3) / 6);
   endfunction

   function automatic void make_sine();
      longint unsigned a, a2, term;
      longint sum, q;
      longint unsigned k;
      bit neg;
      for (int i = 0; i <= 1024; i++) begin
         a = (PI_Q30 * longint'(i) + 1024) / 2048;
         a2 = (a * a + (64'd1 << 29)) >> 30;
         term = a;
         sum = longint'(a);
         k = 2;
         neg = 1'b1;
         while (term != 0 && k < 64) begin
            term = ((term * a2) >> 30) / (k * (k + 1));
            sum = neg ? sum - longint'(term) : sum + longint'(term);
            neg = !neg;
            k += 2;
         end
         if (sum < 0) sum = 0;
         q = (sum + 32) >>> 6;
         if (q > (64'sd1 <<< 24)) q = 64'sd1 <<< 24;
         sine_tab[i] = q;
      end
   endfunction

   function automatic longint sine_of_pi(logic [31:0] u);
      longint unsigned frac, ix;
      logic [1:0] quad;
      longint r;
      frac = u[22:0];
      quad = u[24:23];
      ix = (frac * 1024) >> 23;
      r = quad[0] ? sine_tab[1024 - ix] : sine_tab[ix];
      return quad[1] ? -r : r;
   endfunction

   function automatic void lorentz_kick(longint x, longint z, longint v [3],
                                        output longint dv [3]);
      longint avg, dif, s, c, bz, bx;
      logic [31:0] zu;
      avg = sat32(((64'sd1 <<< 24) + field_c0) >>> 1);
      dif = sat32(((64'sd1 <<< 24) - field_c0) >>> 1);
      zu = z[31:0];
      s = sine_of_pi(zu);
      c = sine_of_pi(zu + 32'h0080_0000);
      bz = sat32(avg + fmul(dif, c));
      bx = fmul(fmul(fmul(longint'(PI_Q), dif), s), x);
      dv[0] = fmul(sat32(-fmul(bz, v[1])), step_dt);
      dv[1] = fmul(sat32(fmul(bz, v[0]) - fmul(bx, v[2])), step_dt);
      dv[2] = fmul(fmul(bx, v[1]), step_dt);
   endfunction

   function automatic step_result_type rk4_push(particle_type st);
      step_result_type r;
      longint p [3], v [3], sp [3], sv [3], dv [3];
      longint kp [4][3], kv [4][3];
      longint nt, eps, dp, dvv;
      for (int i = 0; i < 3; i++) begin
         p[i] = st.p[i];
         v[i] = st.v[i];
         sp[i] = p[i];
         sv[i] = v[i];
      end
      for (int s = 0; s < 4; s++) begin
         for (int i = 0; i < 3; i++) kp[s][i] = fmul(sv[i], step_dt);
         lorentz_kick(sp[0], sp[2], sv, dv);
         for (int i = 0; i < 3; i++) kv[s][i] = dv[i];
         for (int i = 0; i < 3; i++) begin
            dp = (s < 2) ? fhalf(kp[s][i]) : kp[s][i];
            dvv = (s < 2) ? fhalf(kv[s][i]) : kv[s][i];
            sp[i] = sat32(p[i] + dp);
            sv[i] = sat32(v[i] + dvv);
         end
      end
      for (int i = 0; i < 3; i++) begin
         r.np[i] = q_type'(sat32(p[i] + div_round6(kp[0][i] + 2 * kp[1][i]
                                                  + 2 * kp[2][i] + kp[3][i])));
         r.nv[i] = q_type'(sat32(v[i] + div_round6(kv[0][i] + 2 * kv[1][i]
                                                  + 2 * kv[2][i] + kv[3][i])));
      end
      nt = sat32(longint'(st.t) + step_dt);
      r.nt = q_type'(nt);
      eps = longint'(EPS_Q);
      r.go = (longint'(r.np[2]) < (64'sd1 <<< 24) && longint'(r.np[2]) > -eps
              && nt < longint'(st.lim));
      return r;
   endfunction

   function automatic q_type rand_word();
      case ($urandom_range(0, 5))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return q_type'($urandom);
         default: return q_type'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      endcase
   endfunction

   function automatic particle_type rand_particle(bit wild);
      particle_type st;
      for (int i = 0; i < 3; i++) begin
         st.p[i] = wild ? q_type'($urandom) : rand_word();
         st.v[i] = wild ? q_type'($urandom) : rand_word();
      end
      if (!wild && $urandom_range(0, 1)) begin
         st.p[2] = q_type'($urandom_range(0, 32'h0100_0000)) - 32'sh0002_0000;
      end
      st.t = wild ? q_type'($urandom) : q_type'($urandom_range(0, 32'h0200_0000));
      st.lim = wild ? q_type'($urandom) : q_type'($urandom_range(0, 32'h0200_0000));
      return st;
   endfunction

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == 3'(REG_FIELD_RATIO) * 3'd4) field_c0 = longint'($signed(data));
      else step_dt = longint'(data[30:0]);
   endtask

   task automatic run_phase(int count);
      for (int n = 0; n < count; n++) begin
         pending_states.push_back(rand_particle($urandom_range(0, 9) == 0));
      end
      while (pending_states.size() != 0 || expected_steps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      particle_type st;
      logic [31:0] c0_set [4];
      logic [31:0] dt_set [4];
      errors = 0;
      stim_done = 1'b0;
      hold_request = 1'b0;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      field_c0 = 0;
      step_dt = 16777;
      make_sine();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      for (int i = 0; i < 20; i++) begin
         for (int j = 0; j < 3; j++) begin
            st.p[j] = (i % 4 == 0) ? 32'sh7FFFFFFF : (i % 4 == 1) ? 32'sh80000000 : q_type'(0);
            st.v[j] = (i % 4 == 1) ? 32'sh7FFFFFFF : (i % 4 == 0) ? 32'sh80000000
                                                                  : q_type'(32'sh0100_0000);
         end
         st.p[2] = q_type'(i * 32'sh0010_0000) - 32'sh0004_0000;
         st.p[0] = (i > 8) ? q_type'(32'sh0080_0000) : st.p[0];
         st.t = (i == 5) ? 32'sh7FFFFFFF : q_type'(i);
         st.lim = (i == 6) ? 32'sh80000000 : (i == 7) ? 32'sh7FFFFFFF : q_type'(i * 4096);
         pending_states.push_back(st);
      end
      run_phase(300);
      c0_set = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFF00_0000, 32'h0000_0000};
      dt_set = '{32'h0000_0001, 32'h7FFF_FFFF, 32'h0004_0000, 32'h0000_0000};
      for (int ph = 0; ph < 4; ph++) begin
         csr_write(3'(REG_FIELD_RATIO) * 3'd4, c0_set[ph]);
         csr_write(3'(REG_TIME_STEP) * 3'd4, dt_set[ph]);
         if (ph == 1) hold_request = 1'b1;
         run_phase(200);
      end
      csr_write(3'(REG_FIELD_RATIO) * 3'd4, $urandom);
      csr_write(3'(REG_TIME_STEP) * 3'd4, 32'd16777);
      run_phase(680);
      stim_done = 1'b1;
   end

   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         {req.pos_x, req.pos_y, req.pos_z, req.vel_x} <= '0;
         {req.vel_y, req.vel_z, req.time_now, req.time_limit} <= '0;
         gap_left <= 0;
         burst_left <= 4;
      end else begin
         if (req.valid && req.ready) begin
            expected_steps.push_back(rk4_push(pending_states.pop_front()));
         end
         if (!(req.valid && !req.ready)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req.valid <= 1'b0;
            end else if (pending_states.size() > 0) begin
               st = pending_states[0];
               req.valid <= 1'b1;
               req.pos_x <= st.p[0];
               req.pos_y <= st.p[1];
               req.pos_z <= st.p[2];
               req.vel_x <= st.v[0];
               req.vel_y <= st.v[1];
               req.vel_z <= st.v[2];
               req.time_now <= st.t;
               req.time_limit <= st.lim;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      step_result_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
         hold_left <= 0;
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (rsp.valid && rsp.ready) begin
            if (expected_steps.size() == 0) begin
               $display("%0t: unexpected result x=%h", $time, rsp.new_x);
               errors++;
            end else begin
               want = expected_steps.pop_front();
               if ({rsp.new_x, rsp.new_y, rsp.new_z, rsp.new_vx, rsp.new_vy, rsp.new_vz,
                    rsp.new_time, rsp.keep_going} !== {want.np[0], want.np[1], want.np[2],
                    want.nv[0], want.nv[1], want.nv[2], want.nt, want.go}) begin
                  $display("%0t: expected %h %h %h %h %h %h %h %b", $time, want.np[0],
                           want.np[1], want.np[2], want.nv[0], want.nv[1], want.nv[2],
                           want.nt, want.go);
                  $display("%0t: actual   %h %h %h %h %h %h %h %b", $time, rsp.new_x,
                           rsp.new_y, rsp.new_z, rsp.new_vx, rsp.new_vy, rsp.new_vz,
                           rsp.new_time, rsp.keep_going);
                  errors++;
               end
            end
         end
         if (hold_request && hold_left == 0 && expected_steps.size() > 0) begin
            hold_request <= 1'b0;
            hold_left <= 150;
            rsp.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ((cycle_count / 64) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
         end
         if (stim_done) begin
            if (errors == 0) begin
               $display("rk4_magnetic_particle_step_top: match");
            end else begin
               $display("rk4_magnetic_particle_step_top: mismatch");
            end
            $finish;
         end else if (cycle_count > 400000) begin
            $display("rk4_magnetic_particle_step_top: mismatch");
            $finish;
         end
      end
   end

endmodule

// ===== filelist.f =====
sv/rk4mp_pkg.sv
sv/rk4mp_if.sv
sv/rk4mp_stage.sv
sv/rk4_magnetic_particle_step_top.sv
tb/tb.sv
